### rtl/lsr_pkg.sv
package lsr_pkg;

    // Tile defaults
    localparam int TILE_WIDTH_DEF  = 32;
    localparam int TILE_HEIGHT_DEF = 32;

    // Coordinate and color widths
    localparam int COORD_W = 5;
    localparam int CHAN_W  = 8;
    localparam int WORD_W  = 32;

    // Signed width of the running line error and its candidates
    localparam int ERR_W = 10;

    // Fixed alpha byte of every packed pixel
    localparam logic [CHAN_W-1:0] ALPHA = 8'hFF;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

    // Per-line walk constants, loaded at command transfer
    typedef struct packed {
        logic [COORD_W-1:0]      xe;
        logic [COORD_W-1:0]      ye;
        logic signed [ERR_W-1:0] dy;
        logic signed [ERR_W-1:0] sdx;    // dx signed by row direction
        logic                    dir_up; // rows increase along the walk
    } t_walk;

    // One walk step: next position and error, plus end flag of current pixel
    typedef struct packed {
        logic [COORD_W-1:0]      x;
        logic [COORD_W-1:0]      y;
        logic signed [ERR_W-1:0] e;
        logic                    last;
    } t_step;

endpackage

### rtl/lsr_step.sv
// Step unit: least-error diagonal, column or row move; ties go diagonal.
module lsr_step (
    input  logic [lsr_pkg::COORD_W-1:0]      i_x,
    input  logic [lsr_pkg::COORD_W-1:0]      i_y,
    input  logic signed [lsr_pkg::ERR_W-1:0] i_e,
    input  lsr_pkg::t_walk                   i_walk,
    output lsr_pkg::t_step                   o_step
);

    logic signed [lsr_pkg::ERR_W-1:0] ex;
    logic signed [lsr_pkg::ERR_W-1:0] ey;
    logic signed [lsr_pkg::ERR_W-1:0] ed;
    logic [lsr_pkg::ERR_W-1:0]        mag_x;
    logic [lsr_pkg::ERR_W-1:0]        mag_y;
    logic [lsr_pkg::ERR_W-1:0]        mag_d;
    logic [lsr_pkg::COORD_W-1:0]      x_inc;
    logic [lsr_pkg::COORD_W-1:0]      y_mov;
    logic                             at_xe;
    logic                             at_ye;

    // e = dy*(x-xs) - dx*(y-ys); each move adds dy and/or subtracts dir*dx
    assign ex = i_e + i_walk.dy;
    assign ey = i_e - i_walk.sdx;
    assign ed = ex - i_walk.sdx;

    assign mag_x = ex[lsr_pkg::ERR_W-1] ? lsr_pkg::ERR_W'(-ex) : lsr_pkg::ERR_W'(ex);
    assign mag_y = ey[lsr_pkg::ERR_W-1] ? lsr_pkg::ERR_W'(-ey) : lsr_pkg::ERR_W'(ey);
    assign mag_d = ed[lsr_pkg::ERR_W-1] ? lsr_pkg::ERR_W'(-ed) : lsr_pkg::ERR_W'(ed);

    assign x_inc = i_x + lsr_pkg::COORD_W'(1);
    assign y_mov = i_walk.dir_up ? i_y + lsr_pkg::COORD_W'(1) : i_y - lsr_pkg::COORD_W'(1);
    assign at_xe = (i_x == i_walk.xe);
    assign at_ye = (i_y == i_walk.ye);

    always_comb begin
        o_step.last = at_xe && at_ye;
        if (at_xe) begin
            o_step.x = i_x;
            o_step.y = y_mov;
            o_step.e = ey;
        end else if (at_ye) begin
            o_step.x = x_inc;
            o_step.y = i_y;
            o_step.e = ex;
        end else if ((mag_d <= mag_y) && (mag_d <= mag_x)) begin
            o_step.x = x_inc;
            o_step.y = y_mov;
            o_step.e = ed;
        end else if (mag_x <= mag_y) begin
            o_step.x = x_inc;
            o_step.y = i_y;
            o_step.e = ex;
        end else begin
            o_step.x = i_x;
            o_step.y = y_mov;
            o_step.e = ey;
        end
    end

endmodule

### rtl/line_segment_rasterizer.sv
// Channel  | Direction | Handshake               | Payload
// command  | in        | i_in_valid / o_in_ready | start_x/y, end_x/y, red, green, blue
// pixel    | out       | o_out_valid / i_out_ready | pixel_x/y, pixel_word, last_pixel
//
// A command is taken while idle, then the step unit walks one pixel per cycle
// while the output slot is free; a line has at most 32 pixels in a 32x32 tile,
// since every walk step advances along the major axis.
// The command side is ready only while idle; the last pixel may still sit in the
// output register while the next command is transferred.
// Output stalls hold the walk in place; nothing is dropped or repeated.
// i_rst_n is synchronous, active low, and clears the sequencer and output valid.
module line_segment_rasterizer #(
    parameter int TILE_WIDTH  = lsr_pkg::TILE_WIDTH_DEF,
    parameter int TILE_HEIGHT = lsr_pkg::TILE_HEIGHT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // command channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [lsr_pkg::COORD_W-1:0] i_start_x,
    input  logic [lsr_pkg::COORD_W-1:0] i_start_y,
    input  logic [lsr_pkg::COORD_W-1:0] i_end_x,
    input  logic [lsr_pkg::COORD_W-1:0] i_end_y,
    input  logic [lsr_pkg::CHAN_W-1:0]  i_red,
    input  logic [lsr_pkg::CHAN_W-1:0]  i_green,
    input  logic [lsr_pkg::CHAN_W-1:0]  i_blue,
    // pixel channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [lsr_pkg::COORD_W-1:0] o_pixel_x,
    output logic [lsr_pkg::COORD_W-1:0] o_pixel_y,
    output logic [lsr_pkg::WORD_W-1:0]  o_pixel_word,
    output logic                        o_last_pixel
);

    localparam int CW = lsr_pkg::COORD_W;
    localparam int EW = lsr_pkg::ERR_W;
    localparam logic [CW-1:0] X_MAX = CW'(TILE_WIDTH - 1);
    localparam logic [CW-1:0] Y_MAX = CW'(TILE_HEIGHT - 1);

    lsr_pkg::t_state r_state;
    lsr_pkg::t_state n_state;

    // walk registers
    logic [CW-1:0]         r_x;
    logic [CW-1:0]         r_y;
    logic signed [EW-1:0]  r_e;
    lsr_pkg::t_walk        r_walk;
    logic [3*lsr_pkg::CHAN_W-1:0] r_rgb;

    // output register
    logic                  r_out_valid;
    logic [CW-1:0]         r_pix_x;
    logic [CW-1:0]         r_pix_y;
    logic [lsr_pkg::WORD_W-1:0] r_pix_word;
    logic                  r_pix_last;

    // setup datapath
    logic [CW-1:0]         x0, y0, x1, y1;
    logic [CW-1:0]         xs, ys, xe, ye;
    logic [CW-1:0]         dx;
    logic signed [EW-1:0]  dx_w;
    logic                  vert;
    lsr_pkg::t_walk        setup_walk;

    logic                  cmd_xfer;
    logic                  advance;
    logic                  emit;
    lsr_pkg::t_step        step;

    // Clamp endpoints to the tile
    assign x0 = (i_start_x > X_MAX) ? X_MAX : i_start_x;
    assign y0 = (i_start_y > Y_MAX) ? Y_MAX : i_start_y;
    assign x1 = (i_end_x   > X_MAX) ? X_MAX : i_end_x;
    assign y1 = (i_end_y   > Y_MAX) ? Y_MAX : i_end_y;

    // Vertical lines run low row to high row; everything else from the left end.
    // Horizontal lines fall out of the general walk since only column moves remain.
    always_comb begin
        vert = (x0 == x1);
        if (vert) begin
            xs = x0;
            xe = x0;
            ys = (y0 < y1) ? y0 : y1;
            ye = (y0 < y1) ? y1 : y0;
        end else if (x0 < x1) begin
            xs = x0;
            ys = y0;
            xe = x1;
            ye = y1;
        end else begin
            xs = x1;
            ys = y1;
            xe = x0;
            ye = y0;
        end
        dx   = xe - xs;
        dx_w = $signed({{(EW-CW){1'b0}}, dx});
        setup_walk.xe     = xe;
        setup_walk.ye     = ye;
        setup_walk.dy     = $signed({{(EW-CW){1'b0}}, ye}) - $signed({{(EW-CW){1'b0}}, ys});
        setup_walk.dir_up = vert || (ye > ys);
        setup_walk.sdx    = setup_walk.dir_up ? dx_w : -dx_w;
    end

    lsr_step u_step (
        .i_x    (r_x),
        .i_y    (r_y),
        .i_e    (r_e),
        .i_walk (r_walk),
        .o_step (step)
    );

    // Output slot is free when empty or being drained this cycle
    assign advance  = !r_out_valid || i_out_ready;
    assign cmd_xfer = i_in_valid && o_in_ready;

    // Next-state logic
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lsr_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = lsr_pkg::ST_WALK;
                end
            end
            lsr_pkg::ST_WALK: begin
                if (advance && step.last) begin
                    n_state = lsr_pkg::ST_IDLE;
                end
            end
            default: n_state = lsr_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_in_ready = 1'b0;
        emit       = 1'b0;
        unique case (r_state)
            lsr_pkg::ST_IDLE: o_in_ready = 1'b1;
            lsr_pkg::ST_WALK: emit       = advance;
            default: begin
                o_in_ready = 1'b0;
                emit       = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lsr_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Walk and output payload
    always_ff @(posedge i_clk) begin
        if (cmd_xfer) begin
            r_x    <= xs;
            r_y    <= ys;
            r_e    <= '0;
            r_walk <= setup_walk;
            r_rgb  <= {i_red, i_green, i_blue};
        end else if (emit) begin
            r_x <= step.x;
            r_y <= step.y;
            r_e <= step.e;
        end
        if (emit) begin
            r_pix_x    <= r_x;
            r_pix_y    <= r_y;
            r_pix_word <= {r_rgb, lsr_pkg::ALPHA};
            r_pix_last <= step.last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_x    = r_pix_x;
    assign o_pixel_y    = r_pix_y;
    assign o_pixel_word = r_pix_word;
    assign o_last_pixel = r_pix_last;

endmodule
